// File: src/cic_pkg.sv
// Package for the controller input conditioner: sizes, codes, register
// indexes and the structs shared by the modules. Depends on nothing.
`default_nettype none

package cic_pkg;

    // Channel counts of the per-channel state.
    localparam int SLIDER_CHANNELS = 32;
    localparam int AIR_CHANNELS    = 6;
    localparam int SL_IDX_W  = (SLIDER_CHANNELS > 1) ? $clog2(SLIDER_CHANNELS) : 1;
    localparam int AIR_IDX_W = (AIR_CHANNELS > 1) ? $clog2(AIR_CHANNELS) : 1;

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int CHAN_W  = 5;
    localparam int VAL_W   = 8;
    localparam int PID_W   = 32;
    localparam int ALPHA_W = 9;
    localparam int AVG_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_ON_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_OFF_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_FRAMES   = 3'd4;

    // Register reset values.
    localparam logic [VAL_W-1:0]   RST_DEADZONE  = 8'd0;
    localparam logic [ALPHA_W-1:0] RST_ALPHA     = 9'd0;
    localparam logic [VAL_W-1:0]   RST_AIR_ON    = 8'd128;
    localparam logic [VAL_W-1:0]   RST_AIR_OFF   = 8'd64;
    localparam logic [VAL_W-1:0]   RST_DEBOUNCE  = 8'd2;

    // Full weight of the average, in 1/256 steps.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // Element kinds.
    localparam logic [KIND_W-1:0] KIND_SLIDER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AIR     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SERVICE = 2'd3;

    // Current configuration.
    typedef struct packed {
        logic [VAL_W-1:0]   deadzone;
        logic [ALPHA_W-1:0] ema_alpha;
        logic [VAL_W-1:0]   air_on_threshold;
        logic [VAL_W-1:0]   air_off_threshold;
        logic [VAL_W-1:0]   debounce_frames;
    } t_cfg;

    // One sensor element.
    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [CHAN_W-1:0] channel;
        logic [VAL_W-1:0]  raw_value;
        logic [PID_W-1:0]  pkt_id;
        logic              packet_start;
    } t_in_item;

    // Result of conditioning one element.
    typedef struct packed {
        logic              has_result;
        logic [KIND_W-1:0] out_kind;
        logic [CHAN_W-1:0] out_channel;
        logic [VAL_W-1:0]  out_value;
    } t_cond_res;

endpackage

`default_nettype wire

// File: src/cic_if.sv
// Handshake channel interfaces of the controller input conditioner:
// element input, result output and configuration write. Uses cic_pkg.
`default_nettype none

interface cic_in_if;
    logic                       valid;
    logic                       ready;
    logic [cic_pkg::KIND_W-1:0] req_type;
    logic [cic_pkg::CHAN_W-1:0] channel;
    logic [cic_pkg::VAL_W-1:0]  raw_value;
    logic [cic_pkg::PID_W-1:0]  pkt_id;
    logic                       packet_start;

    modport source (output valid, req_type, channel, raw_value, pkt_id, packet_start,
                    input ready);
    modport sink (input valid, req_type, channel, raw_value, pkt_id, packet_start,
                  output ready);
endinterface

interface cic_out_if;
    logic                       valid;
    logic                       ready;
    logic [cic_pkg::KIND_W-1:0] out_kind;
    logic [cic_pkg::CHAN_W-1:0] out_channel;
    logic [cic_pkg::VAL_W-1:0]  out_value;

    modport source (output valid, out_kind, out_channel, out_value, input ready);
    modport sink (input valid, out_kind, out_channel, out_value, output ready);
endinterface

interface cic_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cic_pkg::CFG_IDX_W-1:0]  index;
    logic [cic_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/cic_cfg_regs.sv
// Configuration register file of the controller input conditioner.
// Uses cic_pkg and the cic_cfg_if interface.
`default_nettype none

module cic_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    cic_cfg_if.sink             i_cfg,
    output cic_pkg::t_cfg       o_cfg
);

    cic_pkg::t_cfg r_cfg;

    // Writes are always taken; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadzone          <= cic_pkg::RST_DEADZONE;
            r_cfg.ema_alpha         <= cic_pkg::RST_ALPHA;
            r_cfg.air_on_threshold  <= cic_pkg::RST_AIR_ON;
            r_cfg.air_off_threshold <= cic_pkg::RST_AIR_OFF;
            r_cfg.debounce_frames   <= cic_pkg::RST_DEBOUNCE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cic_pkg::CFG_DEADZONE:
                    r_cfg.deadzone <= i_cfg.data[cic_pkg::VAL_W-1:0];
                cic_pkg::CFG_EMA_ALPHA:
                    r_cfg.ema_alpha <= i_cfg.data[cic_pkg::ALPHA_W-1:0];
                cic_pkg::CFG_AIR_ON_THRESHOLD:
                    r_cfg.air_on_threshold <= i_cfg.data[cic_pkg::VAL_W-1:0];
                cic_pkg::CFG_AIR_OFF_THRESHOLD:
                    r_cfg.air_off_threshold <= i_cfg.data[cic_pkg::VAL_W-1:0];
                cic_pkg::CFG_DEBOUNCE_FRAMES:
                    r_cfg.debounce_frames <= i_cfg.data[cic_pkg::VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/cic_cond.sv
// Per-channel state and single-pass conditioning of one element: packet
// duplicate check, slider deadzone and average, air hysteresis, button
// debounce. Uses cic_pkg.
`default_nettype none

module cic_cond (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cic_pkg::t_cfg      i_cfg,
    input  wire cic_pkg::t_in_item  i_item,
    input  wire logic               i_commit,
    output cic_pkg::t_cond_res      o_res
);

    // State.
    logic [cic_pkg::AVG_W-1:0] r_slider_avg [cic_pkg::SLIDER_CHANNELS];
    logic [cic_pkg::AIR_CHANNELS-1:0] r_air_active;
    logic [cic_pkg::VAL_W-1:0] r_btn_last  [2];
    logic [cic_pkg::VAL_W-1:0] r_btn_count [2];
    logic [cic_pkg::VAL_W-1:0] r_btn_stable[2];
    logic [cic_pkg::PID_W-1:0] r_prev_pid;
    logic                      r_seen;
    logic                      r_drop;

    // Next values and decode.
    logic                         n_drop;
    logic                         dup;
    logic                         is_slider;
    logic                         is_air;
    logic                         is_button;
    logic                         sl_in_range;
    logic                         air_in_range;
    logic [cic_pkg::SL_IDX_W-1:0] sl_idx;
    logic [cic_pkg::AIR_IDX_W-1:0] air_idx;
    logic                         btn_idx;
    logic [cic_pkg::VAL_W-1:0]    x;
    logic [cic_pkg::ALPHA_W-1:0]  a;
    logic [cic_pkg::ALPHA_W-1:0]  a_inv;
    logic [cic_pkg::AVG_W-1:0]    avg_cur;
    logic [16:0]                  prod_new;
    logic [24:0]                  prod_old;
    logic [25:0]                  acc;
    logic [cic_pkg::AVG_W-1:0]    n_avg;
    logic                         air_cur;
    logic                         n_air;
    logic                         btn_same;
    logic                         btn_count_up;
    logic [cic_pkg::VAL_W-1:0]    n_btn_stable;
    logic [cic_pkg::VAL_W-1:0]    value;

    // Duplicate packet check at packet start.
    assign dup    = r_seen && (i_item.pkt_id != '0) && (i_item.pkt_id == r_prev_pid);
    assign n_drop = i_item.packet_start ? dup : r_drop;

    // Kind decode and channel range checks.
    assign is_slider    = (i_item.req_type == cic_pkg::KIND_SLIDER);
    assign is_air       = (i_item.req_type == cic_pkg::KIND_AIR);
    assign is_button    = (i_item.req_type == cic_pkg::KIND_TEST) ||
                          (i_item.req_type == cic_pkg::KIND_SERVICE);
    assign sl_in_range  = ({1'b0, i_item.channel} < 6'(cic_pkg::SLIDER_CHANNELS));
    assign air_in_range = ({1'b0, i_item.channel} < 6'(cic_pkg::AIR_CHANNELS));
    assign sl_idx       = i_item.channel[cic_pkg::SL_IDX_W-1:0];
    assign air_idx      = i_item.channel[cic_pkg::AIR_IDX_W-1:0];
    assign btn_idx      = (i_item.req_type == cic_pkg::KIND_SERVICE);

    // Slider: deadzone, then average weighted by the clamped alpha.
    assign x        = (i_item.raw_value <= i_cfg.deadzone) ? '0 : i_item.raw_value;
    assign a        = (i_cfg.ema_alpha > cic_pkg::ALPHA_ONE) ? cic_pkg::ALPHA_ONE
                                                             : i_cfg.ema_alpha;
    assign a_inv    = cic_pkg::ALPHA_ONE - a;
    assign avg_cur  = r_slider_avg[sl_idx];
    assign prod_new = 17'(a * x);
    assign prod_old = 25'(a_inv * avg_cur);
    assign acc      = {1'b0, prod_new, 8'd0} + {1'b0, prod_old};
    assign n_avg    = acc[23:8];

    // Air: hysteresis between the on and off thresholds.
    assign air_cur = r_air_active[air_idx];
    always_comb begin
        n_air = air_cur;
        if (!air_cur && (i_item.raw_value >= i_cfg.air_on_threshold)) begin
            n_air = 1'b1;
        end else if (air_cur && (i_item.raw_value <= i_cfg.air_off_threshold)) begin
            n_air = 1'b0;
        end
    end

    // Button: confirm a level once it has held for the set frame count.
    assign btn_same     = (i_item.raw_value == r_btn_last[btn_idx]);
    assign btn_count_up = btn_same && (r_btn_count[btn_idx] < i_cfg.debounce_frames);
    assign n_btn_stable = (btn_same && !btn_count_up) ? i_item.raw_value
                                                      : r_btn_stable[btn_idx];

    // Result selection.
    always_comb begin
        value             = '0;
        o_res.has_result  = 1'b0;
        o_res.out_kind    = i_item.req_type;
        o_res.out_channel = i_item.channel;
        if (is_slider) begin
            value            = (a == '0) ? x : n_avg[15:8];
            o_res.has_result = !n_drop && sl_in_range;
        end else if (is_air) begin
            value            = n_air ? i_item.raw_value : '0;
            o_res.has_result = !n_drop && air_in_range;
        end else begin
            value             = n_btn_stable;
            o_res.out_channel = '0;
            o_res.has_result  = !n_drop;
        end
        o_res.out_value = value;
    end

    // Packet tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pid <= '0;
            r_seen     <= 1'b0;
            r_drop     <= 1'b0;
        end else if (i_commit && i_item.packet_start) begin
            r_drop <= dup;
            if (!dup) begin
                r_prev_pid <= i_item.pkt_id;
                r_seen     <= 1'b1;
            end
        end
    end

    // Per-channel conditioning state, written once per committed element.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cic_pkg::SLIDER_CHANNELS; i++) begin
                r_slider_avg[i] <= '0;
            end
            r_air_active <= '0;
            for (int i = 0; i < 2; i++) begin
                r_btn_last[i]   <= '0;
                r_btn_count[i]  <= '0;
                r_btn_stable[i] <= '0;
            end
        end else if (i_commit && !n_drop) begin
            if (is_slider && sl_in_range && (a != '0)) begin
                r_slider_avg[sl_idx] <= n_avg;
            end
            if (is_air && air_in_range) begin
                r_air_active[air_idx] <= n_air;
            end
            if (is_button) begin
                r_btn_stable[btn_idx] <= n_btn_stable;
                if (!btn_same) begin
                    r_btn_last[btn_idx]  <= i_item.raw_value;
                    r_btn_count[btn_idx] <= 8'd1;
                end else if (btn_count_up) begin
                    r_btn_count[btn_idx] <= r_btn_count[btn_idx] + 8'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/controller_input_conditioner.sv
// Controller input conditioner: an input register, one pass of conditioning
// against per-channel state, and a result register.
// Throughput: one element per cycle unless a result held in the result register
// is not taken; the per-channel state is updated as each element moves from
// the input register to the result register.
// Reset (synchronous, active low) clears the valid flags and per-channel state and loads register defaults.
`default_nettype none

module controller_input_conditioner (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cic_in_if.sink    i_in,
    cic_cfg_if.sink   i_cfg,
    cic_out_if.source o_out
);

    cic_pkg::t_cfg      cfg;
    cic_pkg::t_in_item  r_s1_item;
    logic               r_s1_valid;
    cic_pkg::t_cond_res res;
    logic               s1_go;
    logic               r_out_valid;
    logic [cic_pkg::KIND_W-1:0] r_out_kind;
    logic [cic_pkg::CHAN_W-1:0] r_out_channel;
    logic [cic_pkg::VAL_W-1:0]  r_out_value;

    cic_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cic_cond u_cond (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_s1_item),
        .i_commit (s1_go),
        .o_res    (res)
    );

    // The held element moves on whenever the result register is free.
    assign s1_go      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_item.req_type     <= i_in.req_type;
            r_s1_item.channel      <= i_in.channel;
            r_s1_item.raw_value    <= i_in.raw_value;
            r_s1_item.pkt_id       <= i_in.pkt_id;
            r_s1_item.packet_start <= i_in.packet_start;
        end
    end

    // Result register; dropped elements and out-of-range channels leave it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= res.has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_kind    <= res.out_kind;
            r_out_channel <= res.out_channel;
            r_out_value   <= res.out_value;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_kind    = r_out_kind;
    assign o_out.out_channel = r_out_channel;
    assign o_out.out_value   = r_out_value;

endmodule

`default_nettype wire

// File: tb/sv/cic_result_checker.sv
// Result checker for the controller input conditioner: watches the element,
// configuration and result channels, predicts each result and compares it.
// Depends on cic_pkg and the channel interfaces in cic_if.sv.
`default_nettype none

module cic_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cic_in_if    i_elem,
    cic_cfg_if   i_cfg,
    cic_out_if   i_res,
    output int   o_pending,
    output int   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    cic_pkg::t_cfg cur_cfg;

    // Shadow copy of the per-channel conditioning state.
    logic [cic_pkg::AVG_W-1:0] slider_avg [cic_pkg::SLIDER_CHANNELS];
    logic                      air_on     [cic_pkg::AIR_CHANNELS];
    logic [cic_pkg::VAL_W-1:0] btn_last   [2];
    logic [cic_pkg::VAL_W-1:0] btn_count  [2];
    logic [cic_pkg::VAL_W-1:0] btn_stable [2];
    logic [cic_pkg::PID_W-1:0] last_pid;
    logic                      pid_seen;
    logic                      drop_pkt;

    cic_pkg::t_cond_res expected_results [$];
    int                 error_total = 0;

    // Works out the result of one element and advances the shadow state.
    function automatic cic_pkg::t_cond_res condition_element(input cic_pkg::t_in_item elem);
        cic_pkg::t_cond_res          res;
        logic [cic_pkg::VAL_W-1:0]   x;
        logic [cic_pkg::ALPHA_W-1:0] a;
        logic [31:0]                 acc;
        int                          b;
        res = '0;
        if (elem.packet_start) begin
            if (pid_seen && elem.pkt_id != '0 && elem.pkt_id == last_pid) begin
                drop_pkt = 1'b1;
            end else begin
                drop_pkt = 1'b0;
                last_pid = elem.pkt_id;
                pid_seen = 1'b1;
            end
        end
        if (drop_pkt) return res;

        res.has_result  = 1'b1;
        res.out_kind    = elem.req_type;
        res.out_channel = elem.channel;
        case (elem.req_type)
            cic_pkg::KIND_SLIDER: begin
                if (elem.channel >= cic_pkg::SLIDER_CHANNELS) return '0;
                x = (elem.raw_value <= cur_cfg.deadzone) ? '0 : elem.raw_value;
                a = (cur_cfg.ema_alpha > cic_pkg::ALPHA_ONE) ? cic_pkg::ALPHA_ONE
                                                             : cur_cfg.ema_alpha;
                if (a == '0) begin
                    res.out_value = x;
                end else begin
                    // Weighted sum with 16 fraction bits, truncated back to the Q8.8 state width.
                    acc = 32'(a) * {16'd0, x, 8'd0}
                        + (32'(cic_pkg::ALPHA_ONE) - 32'(a)) * 32'(slider_avg[elem.channel]);
                    slider_avg[elem.channel] = acc[23:8];
                    res.out_value = slider_avg[elem.channel][15:8];
                end
            end
            cic_pkg::KIND_AIR: begin
                if (elem.channel >= cic_pkg::AIR_CHANNELS) return '0;
                if (!air_on[elem.channel] &&
                    elem.raw_value >= cur_cfg.air_on_threshold) begin
                    air_on[elem.channel] = 1'b1;
                end else if (air_on[elem.channel] &&
                             elem.raw_value <= cur_cfg.air_off_threshold) begin
                    air_on[elem.channel] = 1'b0;
                end
                res.out_value = air_on[elem.channel] ? elem.raw_value : '0;
            end
            default: begin
                b = (elem.req_type == cic_pkg::KIND_SERVICE) ? 1 : 0;
                if (elem.raw_value == btn_last[b]) begin
                    if (btn_count[b] < cur_cfg.debounce_frames) begin
                        btn_count[b] = btn_count[b] + 8'd1;
                    end else begin
                        btn_stable[b] = elem.raw_value;
                    end
                end else begin
                    btn_last[b]  = elem.raw_value;
                    btn_count[b] = 8'd1;
                end
                res.out_value   = btn_stable[b];
                res.out_channel = '0;
            end
        endcase
        return res;
    endfunction

    // Sample all three channels at each edge; results are checked before new
    // expectations are queued so a stray beat never matches a fresh one.
    always @(posedge i_clk) begin : monitor
        cic_pkg::t_in_item  elem;
        cic_pkg::t_cond_res want;
        if (!i_rst_n) begin
            cur_cfg.deadzone          = cic_pkg::RST_DEADZONE;
            cur_cfg.ema_alpha         = cic_pkg::RST_ALPHA;
            cur_cfg.air_on_threshold  = cic_pkg::RST_AIR_ON;
            cur_cfg.air_off_threshold = cic_pkg::RST_AIR_OFF;
            cur_cfg.debounce_frames   = cic_pkg::RST_DEBOUNCE;
            for (int i = 0; i < cic_pkg::SLIDER_CHANNELS; i++) slider_avg[i] = '0;
            for (int i = 0; i < cic_pkg::AIR_CHANNELS; i++) air_on[i] = 1'b0;
            for (int i = 0; i < 2; i++) begin
                btn_last[i]   = '0;
                btn_count[i]  = '0;
                btn_stable[i] = '0;
            end
            last_pid = '0;
            pid_seen = 1'b0;
            drop_pkt = 1'b0;
            expected_results.delete();
        end else begin
            // Register writes.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    cic_pkg::CFG_DEADZONE:
                        cur_cfg.deadzone = i_cfg.data[cic_pkg::VAL_W-1:0];
                    cic_pkg::CFG_EMA_ALPHA:
                        cur_cfg.ema_alpha = i_cfg.data[cic_pkg::ALPHA_W-1:0];
                    cic_pkg::CFG_AIR_ON_THRESHOLD:
                        cur_cfg.air_on_threshold = i_cfg.data[cic_pkg::VAL_W-1:0];
                    cic_pkg::CFG_AIR_OFF_THRESHOLD:
                        cur_cfg.air_off_threshold = i_cfg.data[cic_pkg::VAL_W-1:0];
                    cic_pkg::CFG_DEBOUNCE_FRAMES:
                        cur_cfg.debounce_frames = i_cfg.data[cic_pkg::VAL_W-1:0];
                    default: ;
                endcase
            end

            // Result beats against the oldest expectation.
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    error_total++;
                    $error("result beat with nothing expected: kind %0d channel %0d value %0d",
                           i_res.out_kind, i_res.out_channel, i_res.out_value);
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.out_kind !== want.out_kind) begin
                        error_total++;
                        $error("out_kind mismatch: expected %0d, actual %0d",
                               want.out_kind, i_res.out_kind);
                    end
                    if (i_res.out_channel !== want.out_channel) begin
                        error_total++;
                        $error("out_channel mismatch: expected %0d, actual %0d",
                               want.out_channel, i_res.out_channel);
                    end
                    if (i_res.out_value !== want.out_value) begin
                        error_total++;
                        $error("out_value mismatch: expected %0d, actual %0d",
                               want.out_value, i_res.out_value);
                    end
                end
            end

            // Element beats produce at most one expectation each.
            if (i_elem.valid && i_elem.ready) begin
                elem.req_type     = i_elem.req_type;
                elem.channel      = i_elem.channel;
                elem.raw_value    = i_elem.raw_value;
                elem.pkt_id       = i_elem.pkt_id;
                elem.packet_start = i_elem.packet_start;
                want = condition_element(elem);
                if (want.has_result) expected_results.push_back(want);
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= error_total;
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Top of the controller input conditioner testbench: clock, reset, element
// and register stimulus, result back-pressure and the verdict.
// Depends on cic_pkg, cic_if.sv, the block and cic_result_checker.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_SLACK     = 6;
    localparam int CYCLE_LIMIT     = 200000;

    logic i_clk;
    logic i_rst_n;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pending_results;
    int mismatch_count;
    int cycle_count    = 0;
    int items_sent;

    // Stimulus shaping: recent packet id, held button levels, thresholds.
    logic [cic_pkg::PID_W-1:0] prev_pid;
    logic [cic_pkg::VAL_W-1:0] btn_level [2];
    logic [cic_pkg::VAL_W-1:0] cur_deadzone;
    logic [cic_pkg::VAL_W-1:0] cur_on;
    logic [cic_pkg::VAL_W-1:0] cur_off;

    cic_in_if  elem_bus ();
    cic_out_if res_bus ();
    cic_cfg_if cfg_bus ();

    controller_input_conditioner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (elem_bus),
        .i_cfg   (cfg_bus),
        .o_out   (res_bus)
    );

    cic_result_checker u_result_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_elem    (elem_bus),
        .i_cfg     (cfg_bus),
        .i_res     (res_bus),
        .o_pending (pending_results),
        .o_errors  (mismatch_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("controller_input_conditioner test failed");
            $finish;
        end
    end

    // Result back-pressure.
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One element beat, after a random number of idle cycles.
    task automatic send_element(input logic [cic_pkg::KIND_W-1:0] kind,
                                input logic [cic_pkg::CHAN_W-1:0] chan,
                                input logic [cic_pkg::VAL_W-1:0] raw,
                                input logic [cic_pkg::PID_W-1:0] pid,
                                input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            elem_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        elem_bus.valid        <= 1'b1;
        elem_bus.req_type     <= kind;
        elem_bus.channel      <= chan;
        elem_bus.raw_value    <= raw;
        elem_bus.pkt_id       <= pid;
        elem_bus.packet_start <= start;
        do @(posedge i_clk); while (!elem_bus.ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [cic_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cic_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    // Hold off until every expected result is in and the pipeline is empty.
    task automatic wait_idle();
        elem_bus.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Register settings per phase: extremes first, defaults again later.
    task automatic apply_setting(input int phase);
        logic [cic_pkg::CFG_DATA_W-1:0] dz, al, on_t, off_t, db;
        case (phase)
            0: begin dz = 9'd0;   al = 9'd256; on_t = 9'd255; off_t = 9'd0;   db = 9'd0;   end
            1: begin dz = 9'h1FF; al = 9'd1;   on_t = 9'd0;   off_t = 9'd255; db = 9'd255; end
            2: begin dz = 9'd40;  al = 9'd511; on_t = 9'd100; off_t = 9'd100; db = 9'd1;   end
            3: begin dz = 9'd16;  al = 9'd128; on_t = 9'd200; off_t = 9'd50;  db = 9'd3;   end
            6: begin dz = 9'd0;   al = 9'd0;   on_t = 9'd128; off_t = 9'd64;  db = 9'd2;   end
            default: begin
                dz    = 9'($urandom_range(511));
                al    = 9'($urandom_range(511));
                on_t  = 9'($urandom_range(511));
                off_t = 9'($urandom_range(511));
                db    = {1'($urandom_range(1)), 8'($urandom_range(7))};
            end
        endcase
        write_reg(cic_pkg::CFG_DEADZONE, dz);
        write_reg(cic_pkg::CFG_EMA_ALPHA, al);
        write_reg(cic_pkg::CFG_AIR_ON_THRESHOLD, on_t);
        write_reg(cic_pkg::CFG_AIR_OFF_THRESHOLD, off_t);
        write_reg(cic_pkg::CFG_DEBOUNCE_FRAMES, db);
        cfg_bus.valid <= 1'b0;
        cur_deadzone = dz[cic_pkg::VAL_W-1:0];
        cur_on       = on_t[cic_pkg::VAL_W-1:0];
        cur_off      = off_t[cic_pkg::VAL_W-1:0];
    endtask

    // Samples lean toward the extremes and the current decision points.
    function automatic logic [cic_pkg::VAL_W-1:0] pick_sample();
        int                        r;
        logic [cic_pkg::VAL_W-1:0] base;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 50) begin
            case ($urandom_range(2))
                0:       base = cur_on;
                1:       base = cur_off;
                default: base = cur_deadzone;
            endcase
            return base + 8'($urandom_range(6)) - 8'd3;
        end
        return 8'($urandom_range(255));
    endfunction

    // A packet of one to eight elements; now and then a repeated or zero id,
    // a missing start flag or a stray start in the middle.
    task automatic send_packet();
        int                         r;
        int                         len;
        int                         b;
        logic [cic_pkg::PID_W-1:0]  pid;
        logic [cic_pkg::KIND_W-1:0] kind;
        logic [cic_pkg::CHAN_W-1:0] chan;
        logic [cic_pkg::VAL_W-1:0]  raw;
        logic                       start;
        r = $urandom_range(99);
        if (r < 15)      pid = prev_pid;
        else if (r < 25) pid = '0;
        else             pid = $urandom;
        prev_pid = pid;
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
            kind = 2'($urandom_range(3));
            chan = 5'($urandom_range(31));
            if (kind == cic_pkg::KIND_AIR && $urandom_range(99) < 80) begin
                chan = 5'($urandom_range(cic_pkg::AIR_CHANNELS - 1));
            end
            if (kind == cic_pkg::KIND_TEST || kind == cic_pkg::KIND_SERVICE) begin
                // Buttons mostly hold their level so the debounce can confirm.
                b = (kind == cic_pkg::KIND_SERVICE) ? 1 : 0;
                if ($urandom_range(99) >= 70) btn_level[b] = pick_sample();
                raw = btn_level[b];
            end else begin
                raw = pick_sample();
            end
            start = (i == 0);
            if ($urandom_range(99) < 5) start = !start;
            send_element(kind, chan, raw, pid, start);
        end
    endtask

    // Directed elements at the register defaults.
    task automatic run_directed();
        // Elements ahead of any packet start.
        send_element(cic_pkg::KIND_SLIDER, 5'd0, 8'd255, 32'd0, 1'b0);
        send_element(cic_pkg::KIND_SLIDER, 5'd31, 8'd0, 32'hFFFF_FFFF, 1'b0);
        // Air trigger around the default thresholds, all-ones packet id.
        send_element(cic_pkg::KIND_AIR, 5'd0, 8'd128, 32'hFFFF_FFFF, 1'b1);
        send_element(cic_pkg::KIND_AIR, 5'd0, 8'd65, 32'hFFFF_FFFF, 1'b0);
        send_element(cic_pkg::KIND_AIR, 5'd0, 8'd64, 32'hFFFF_FFFF, 1'b0);
        send_element(cic_pkg::KIND_AIR, 5'd5, 8'd255, 32'hFFFF_FFFF, 1'b0);
        // Air channels past the last sensor.
        send_element(cic_pkg::KIND_AIR, 5'd6, 8'd255, 32'hFFFF_FFFF, 1'b0);
        send_element(cic_pkg::KIND_AIR, 5'd31, 8'd0, 32'hFFFF_FFFF, 1'b0);
        // Button debounce; the channel field is ignored.
        send_element(cic_pkg::KIND_TEST, 5'd31, 8'd255, 32'hFFFF_FFFF, 1'b0);
        send_element(cic_pkg::KIND_TEST, 5'd0, 8'd255, 32'hFFFF_FFFF, 1'b0);
        send_element(cic_pkg::KIND_TEST, 5'd0, 8'd255, 32'hFFFF_FFFF, 1'b0);
        send_element(cic_pkg::KIND_SERVICE, 5'd7, 8'hAA, 32'hFFFF_FFFF, 1'b0);
        // Same nonzero id again: the whole packet is dropped.
        send_element(cic_pkg::KIND_SLIDER, 5'd3, 8'd200, 32'hFFFF_FFFF, 1'b1);
        send_element(cic_pkg::KIND_AIR, 5'd1, 8'd200, 32'hFFFF_FFFF, 1'b0);
        send_element(cic_pkg::KIND_SERVICE, 5'd0, 8'h55, 32'hFFFF_FFFF, 1'b0);
        // A zero id is never a duplicate.
        send_element(cic_pkg::KIND_SLIDER, 5'd3, 8'd200, 32'd0, 1'b1);
        send_element(cic_pkg::KIND_SERVICE, 5'd0, 8'hAA, 32'd0, 1'b1);
        send_element(cic_pkg::KIND_SERVICE, 5'd0, 8'hAA, 32'd0, 1'b0);
        send_element(cic_pkg::KIND_SLIDER, 5'd17, 8'h5A, 32'h5555_5555, 1'b1);
        send_element(cic_pkg::KIND_SLIDER, 5'd17, 8'hA5, 32'hAAAA_AAAA, 1'b1);
    endtask

    // Main sequence: reset, directed elements, then random phases.
    initial begin
        i_rst_n               <= 1'b0;
        elem_bus.valid        <= 1'b0;
        elem_bus.req_type     <= '0;
        elem_bus.channel      <= '0;
        elem_bus.raw_value    <= '0;
        elem_bus.pkt_id       <= '0;
        elem_bus.packet_start <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= '0;
        cfg_bus.data          <= '0;
        prev_pid     = '0;
        btn_level[0] = '0;
        btn_level[1] = '0;
        cur_deadzone = cic_pkg::RST_DEADZONE;
        cur_on       = cic_pkg::RST_AIR_ON;
        cur_off      = cic_pkg::RST_AIR_OFF;
        items_sent   = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(p);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) send_packet();
            wait_idle();
        end

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("controller_input_conditioner test passed");
        end else begin
            $display("controller_input_conditioner test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/cic_pkg.sv
src/cic_if.sv
src/cic_cfg_regs.sv
src/cic_cond.sv
src/controller_input_conditioner.sv
tb/sv/cic_result_checker.sv
tb/sv/tb_top.sv
